// ----- rtl/link_failsafe_rearm_fsm_unit_macros.svh -----
// Assertion helpers for the link failsafe re-arm block.
`ifndef LINK_FAILSAFE_REARM_FSM_UNIT_MACROS_SVH
`define LINK_FAILSAFE_REARM_FSM_UNIT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define LFR_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lfr assertion failed");

// Next-cycle implication.
`define LFR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lfr assertion failed");

`endif

// ----- rtl/lfr_pkg.sv -----
package lfr_pkg;

   localparam int TIME_WIDTH  = 32;
   localparam int COUNT_WIDTH = 16;
   localparam int CSR_IDX_W   = 8;
   // write data as wide as the widest register
   localparam int CSR_DATA_W  = (TIME_WIDTH > COUNT_WIDTH) ? TIME_WIDTH : COUNT_WIDTH;

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LINK_TIMEOUT  = 8'd0,
      CSR_MAX_FRAME_GAP = 8'd1,
      CSR_CONFIRM_TIME  = 8'd2,
      CSR_MIN_FRAMES    = 8'd3
   } csr_idx_type;

   typedef struct packed {
      logic [TIME_WIDTH-1:0]  link_timeout_ms;
      logic [TIME_WIDTH-1:0]  max_frame_gap_ms;
      logic [TIME_WIDTH-1:0]  confirm_time_ms;
      logic [COUNT_WIDTH-1:0] min_frame_count;
   } cfg_type;

   typedef struct packed {
      logic [TIME_WIDTH-1:0] now_ms;
      logic                  frame_arrived;
      logic                  rx_failsafe_flag;
   } tick_type;

   typedef struct packed {
      logic link_mode;
      logic ever_linked;
      logic proof_open;
   } result_type;

endpackage

// ----- rtl/link_failsafe_rearm_fsm_unit.sv -----
// Receiver link failsafe with proven re-arm.
// req_ channel: one beat per tick carrying now_ms, frame_arrived and
// rx_failsafe_flag. rsp_ channel: one beat per tick with link_mode,
// ever_linked and proof_open, in request order.
// csr_ port: write-only; index 0 link timeout, 1 max frame gap, 2 confirm
// time, 3 min frame count. Other indices are ignored. Write only when idle.
// Pipeline: input register -> state update logic -> result register.
// A beat taken into the input register moves into the result register once
// that has room, and is offered on rsp_ from there; throughput is one beat
// per cycle while rsp_ready stays high.
// When rsp_ready is low the result register holds, the input register
// still takes one more beat, then req_ready drops until the result drains.
// Reset (synchronous, active high) empties both stages, puts the link in
// Safe with no window open, clears the latch and reloads the default
// register values (500, 100, 1000, 10).
module link_failsafe_rearm_fsm_unit
   import lfr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [TIME_WIDTH-1:0] req_now_ms,
   input  logic                  req_frame_arrived,
   input  logic                  req_rx_failsafe_flag,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_link_mode,
   output logic                  rsp_ever_linked,
   output logic                  rsp_proof_open,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

`include "link_failsafe_rearm_fsm_unit_macros.svh"

   cfg_type    cfg;
   tick_type   tick;
   result_type result;
   logic       tick_valid;
   logic       rsp_free;
   logic       advance;

   // a held tick moves into the result register once that has room
   assign advance = tick_valid && rsp_free;

   lfr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cfg         (cfg)
   );

   lfr_in_stage u_in (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_now_ms           (req_now_ms),
      .req_frame_arrived    (req_frame_arrived),
      .req_rx_failsafe_flag (req_rx_failsafe_flag),
      .advance              (advance),
      .tick_valid           (tick_valid),
      .tick                 (tick)
   );

   // state registers update only on advance, so each tick is applied once
   lfr_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .tick    (tick),
      .cfg     (cfg),
      .result  (result)
   );

   lfr_rsp_stage u_rsp (
      .clock           (clock),
      .reset           (reset),
      .advance         (advance),
      .result          (result),
      .rsp_free        (rsp_free),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_link_mode   (rsp_link_mode),
      .rsp_ever_linked (rsp_ever_linked),
      .rsp_proof_open  (rsp_proof_open)
   );

   // Active implies the latch has been set.
   `LFR_ASSERT_NOW(a_active_latched, clock, reset, rsp_valid && rsp_link_mode, rsp_ever_linked)
   // No proof window stays open while Active.
   `LFR_ASSERT_NOW(a_active_no_window, clock, reset, rsp_valid && rsp_link_mode, !rsp_proof_open)
   // An empty result register never blocks the request side.
   `LFR_ASSERT_NOW(a_empty_accepts, clock, reset, !rsp_valid, req_ready)
   // A tick that moves into the result register shows up as a response next cycle.
   `LFR_ASSERT_NEXT(a_fill_reaches_rsp, clock, reset, advance, rsp_valid)

endmodule

// ----- rtl/lfr_csr.sv -----
module lfr_csr
   import lfr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data,
   output cfg_type               cfg
);

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.link_timeout_ms  <= TIME_WIDTH'(500);
         cfg_ff.max_frame_gap_ms <= TIME_WIDTH'(100);
         cfg_ff.confirm_time_ms  <= TIME_WIDTH'(1000);
         cfg_ff.min_frame_count  <= COUNT_WIDTH'(10);
      end else if (csr_wr_en) begin
         unique case (csr_idx_type'(csr_index))
            CSR_LINK_TIMEOUT:  cfg_ff.link_timeout_ms  <= csr_wr_data[TIME_WIDTH-1:0];
            CSR_MAX_FRAME_GAP: cfg_ff.max_frame_gap_ms <= csr_wr_data[TIME_WIDTH-1:0];
            CSR_CONFIRM_TIME:  cfg_ff.confirm_time_ms  <= csr_wr_data[TIME_WIDTH-1:0];
            CSR_MIN_FRAMES:    cfg_ff.min_frame_count  <= csr_wr_data[COUNT_WIDTH-1:0];
            default: ; // unmapped index: dropped
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- rtl/lfr_in_stage.sv -----
module lfr_in_stage
   import lfr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [TIME_WIDTH-1:0] req_now_ms,
   input  logic                  req_frame_arrived,
   input  logic                  req_rx_failsafe_flag,
   input  logic                  advance,
   output logic                  tick_valid,
   output tick_type              tick
);

   logic     valid_ff, valid_in;
   tick_type tick_ff;
   logic     take;

   // Free when empty or when the held beat moves on this cycle.
   assign req_ready = !valid_ff || advance;
   assign take      = req_valid && req_ready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         tick_ff.now_ms           <= req_now_ms;
         tick_ff.frame_arrived    <= req_frame_arrived;
         tick_ff.rx_failsafe_flag <= req_rx_failsafe_flag;
      end
   end

   assign tick_valid = valid_ff;
   assign tick       = tick_ff;

endmodule

// ----- rtl/lfr_core.sv -----
module lfr_core
   import lfr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       advance,
   input  tick_type   tick,
   input  cfg_type    cfg,
   output result_type result
);

   logic                   mode_ff,   mode_in;
   logic                   seen_ff,   seen_in;
   logic [TIME_WIDTH-1:0]  last_ff,   last_in;
   logic                   win_ff,    win_in;
   logic [TIME_WIDTH-1:0]  wstart_ff, wstart_in;
   logic [COUNT_WIDTH-1:0] wcount_ff, wcount_in;
   logic                   latch_ff,  latch_in;

   logic [TIME_WIDTH-1:0]  age;
   logic [TIME_WIDTH-1:0]  gap;
   logic [TIME_WIDTH-1:0]  win_age;
   logic                   link_ok;

   always_comb begin
      mode_in   = mode_ff;
      seen_in   = seen_ff  || tick.frame_arrived;
      last_in   = tick.frame_arrived ? tick.now_ms : last_ff;
      win_in    = win_ff;
      wstart_in = wstart_ff;
      wcount_in = wcount_ff;
      latch_in  = latch_ff;

      // all differences wrap modulo 2^TIME_WIDTH
      age     = tick.now_ms - last_in;
      gap     = tick.now_ms - last_ff;   // silence since the previous frame
      win_age = tick.now_ms - wstart_ff;
      link_ok = seen_in && !tick.rx_failsafe_flag && (age < cfg.link_timeout_ms);

      if (!link_ok) begin
         mode_in   = 1'b0;
         win_in    = 1'b0;
         wcount_in = '0;
      end else if (!mode_ff) begin
         if (win_ff && seen_ff && (gap > cfg.max_frame_gap_ms)) begin
            win_in    = 1'b0;
            wcount_in = '0;
         end
         if (!win_in) begin
            if (tick.frame_arrived) begin
               win_in    = 1'b1;
               wstart_in = tick.now_ms;
               wcount_in = COUNT_WIDTH'(1);
            end
         end else begin
            if (tick.frame_arrived && (wcount_in != COUNT_MAX)) begin
               wcount_in = wcount_in + COUNT_WIDTH'(1);
            end
            if ((win_age >= cfg.confirm_time_ms) && (wcount_in >= cfg.min_frame_count)) begin
               mode_in   = 1'b1;
               latch_in  = 1'b1;
               win_in    = 1'b0;
               wcount_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= 1'b0;
         seen_ff   <= 1'b0;
         last_ff   <= '0;
         win_ff    <= 1'b0;
         wstart_ff <= '0;
         wcount_ff <= '0;
         latch_ff  <= 1'b0;
      end else if (advance) begin
         mode_ff   <= mode_in;
         seen_ff   <= seen_in;
         last_ff   <= last_in;
         win_ff    <= win_in;
         wstart_ff <= wstart_in;
         wcount_ff <= wcount_in;
         latch_ff  <= latch_in;
      end
   end

   assign result.link_mode   = mode_in;
   assign result.ever_linked = latch_in;
   assign result.proof_open  = win_in;

endmodule

// ----- rtl/lfr_rsp_stage.sv -----
module lfr_rsp_stage
   import lfr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       advance,
   input  result_type result,
   output logic       rsp_free,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_link_mode,
   output logic       rsp_ever_linked,
   output logic       rsp_proof_open
);

   logic       valid_ff, valid_in;
   result_type data_ff;

   assign rsp_free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (advance) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= result;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_link_mode   = data_ff.link_mode;
   assign rsp_ever_linked = data_ff.ever_linked;
   assign rsp_proof_open  = data_ff.proof_open;

endmodule
